// ===== sv/sha256_pkg.sv =====
// SHA-256 hasher package: round constants, initial hash values and round functions.
// Depends on nothing; used by all modules of the hasher.
package sha256_pkg;

    localparam int unsigned NumRounds = 64;
    localparam int unsigned NumWords = 16;
    localparam int unsigned NumHash = 8;

    typedef logic [31:0] t_word;

    function automatic t_word round_k(input logic [5:0] t);
        t_word k;
        case (t)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic t_word init_hash(input logic [2:0] i);
        t_word h;
        case (i)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    function automatic t_word rotr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word big_sigma0(input t_word x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    // Control from the sequencer to the round unit.
    typedef struct packed {
        logic       load;   // copy chain value into a..h
        logic       round;  // run one round
        logic [5:0] t;      // round index
    } t_round_ctl;

endpackage

// ===== sv/sha256_round.sv =====
// SHA-256 round unit: working variables a..h and one compression round per cycle while i_ctl.round is set.
// Depends on sha256_pkg.
module sha256_round (
    input  logic                    i_clk,
    input  sha256_pkg::t_round_ctl  i_ctl,
    input  sha256_pkg::t_word       i_wt,
    input  sha256_pkg::t_word       i_chain [sha256_pkg::NumHash],
    output sha256_pkg::t_word       o_vars  [sha256_pkg::NumHash]
);
    sha256_pkg::t_word r_v [sha256_pkg::NumHash];
    sha256_pkg::t_word t1, t2;

    always_comb begin
        t1 = r_v[7] + sha256_pkg::big_sigma1(r_v[4])
           + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
           + sha256_pkg::round_k(i_ctl.t) + i_wt;
        t2 = sha256_pkg::big_sigma0(r_v[0])
           + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    // Payload only: loaded before any read.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_v <= i_chain;
        end else if (i_ctl.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    assign o_vars = r_v;
endmodule

// ===== sv/sha256_byte_stream_hasher_top.sv =====
// SHA-256 byte-stream hasher, top level: byte packing, padding, schedule window,
// sequencer and digest output. Depends on sha256_pkg and sha256_round.
//
// Channel | Direction | Handshake           | Payload
// --------+-----------+---------------------+---------------------------------
// input   | in        | i_valid / o_stall   | i_cmd, i_data_byte
// output  | out       | o_valid / i_stall   | o_digest_word, o_word_last
//
// Data bytes are taken back to back while idle; the 64th byte of a block adds a
// compression (one load, 64 rounds on the shared round unit, one chain update).
// Finish runs one or two compressions, then offers eight digest words, one
// per cycle while i_stall is low; the next request is taken after the last word.
// Reset (synchronous, active low) restores the initial hash and clears the block.
// Output stalls hold the digest word; input is stalled throughout a compression.
module sha256_byte_stream_hasher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_cmd,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic        o_word_last
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_LOAD, ST_ROUND, ST_UPDATE, ST_LEN, ST_OUT
    } t_state;

    t_state r_state, n_state;
    sha256_pkg::t_word r_chain [sha256_pkg::NumHash];
    sha256_pkg::t_word n_chain [sha256_pkg::NumHash];
    sha256_pkg::t_word r_blk   [sha256_pkg::NumWords];
    sha256_pkg::t_word n_blk   [sha256_pkg::NumWords];
    sha256_pkg::t_word w_vars  [sha256_pkg::NumHash];
    logic [5:0]  r_pos, n_pos;
    logic [63:0] r_len, n_len;
    logic [5:0]  r_t, n_t;
    logic        r_fin, n_fin;     // compression belongs to a finish request
    logic        r_second, n_second; // a length-only block still follows
    logic [2:0]  r_oidx, n_oidx;
    sha256_pkg::t_round_ctl w_ctl;
    sha256_pkg::t_word w_wt, w_new;
    logic w_acc;
    logic [7:0] w_byte;

    assign o_stall = (r_state != ST_IDLE);
    assign w_acc = i_valid && !o_stall;
    assign w_byte = i_cmd ? 8'h80 : i_data_byte;

    // Rolling schedule: window head is r_blk[0]; shift one word per round.
    assign w_new = sha256_pkg::small_sigma1(r_blk[14]) + r_blk[9]
                 + sha256_pkg::small_sigma0(r_blk[1]) + r_blk[0];
    assign w_wt = (r_t < 6'd16) ? r_blk[0] : w_new;

    always_comb begin
        w_ctl.load = (r_state == ST_LOAD);
        w_ctl.round = (r_state == ST_ROUND);
        w_ctl.t = r_t;
    end

    sha256_round u_round (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_wt   (w_wt),
        .i_chain(r_chain),
        .o_vars (w_vars)
    );

    always_comb begin
        n_state = r_state;
        n_chain = r_chain;
        n_blk = r_blk;
        n_pos = r_pos;
        n_len = r_len;
        n_t = r_t;
        n_fin = r_fin;
        n_second = r_second;
        n_oidx = r_oidx;
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    // Pack the byte (data or the 0x80 pad) big-endian.
                    n_blk[r_pos[5:2]] = r_blk[r_pos[5:2]]
                        | ({24'd0, w_byte} << (5'd24 - {r_pos[1:0], 3'b000}));
                    n_fin = i_cmd;
                    n_t = '0;
                    if (!i_cmd) begin
                        n_len = r_len + 64'd8;
                        n_pos = r_pos + 6'd1;
                        if (r_pos == 6'd63) begin
                            n_state = ST_LOAD;
                        end
                    end else if (r_pos >= 6'd56) begin
                        n_second = 1'b1;
                        n_state = ST_LOAD;
                    end else begin
                        n_second = 1'b0;
                        n_state = ST_LEN;
                    end
                end
            end
            ST_LEN: begin
                n_blk[14] = r_len[63:32];
                n_blk[15] = r_len[31:0];
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                // Advance the window; the block is rebuilt afterwards.
                for (int i = 0; i < 15; i++) begin
                    n_blk[i] = r_blk[i + 1];
                end
                n_blk[15] = w_wt;
                n_t = r_t + 6'd1;
                if (r_t == 6'(sha256_pkg::NumRounds - 1)) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                for (int i = 0; i < 8; i++) begin
                    n_chain[i] = r_chain[i] + w_vars[i];
                end
                for (int i = 0; i < 16; i++) begin
                    n_blk[i] = '0;
                end
                n_t = '0;
                if (!r_fin) begin
                    n_state = ST_IDLE;
                end else if (r_second) begin
                    n_second = 1'b0;
                    n_state = ST_LEN;
                end else begin
                    n_oidx = '0;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!i_stall) begin
                    n_oidx = r_oidx + 3'd1;
                    if (r_oidx == 3'd7) begin
                        // Reinitialize for the next message.
                        for (int i = 0; i < 8; i++) begin
                            n_chain[i] = sha256_pkg::init_hash(3'(i));
                        end
                        n_pos = '0;
                        n_len = '0;
                        n_fin = 1'b0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= sha256_pkg::init_hash(3'(i));
            end
            for (int i = 0; i < 16; i++) begin
                r_blk[i] <= '0;
            end
            r_pos <= '0;
            r_len <= '0;
            r_t <= '0;
            r_fin <= 1'b0;
            r_second <= 1'b0;
            r_oidx <= '0;
        end else begin
            r_state <= n_state;
            r_chain <= n_chain;
            r_blk <= n_blk;
            r_pos <= n_pos;
            r_len <= n_len;
            r_t <= n_t;
            r_fin <= n_fin;
            r_second <= n_second;
            r_oidx <= n_oidx;
        end
    end

    assign o_valid = (r_state == ST_OUT);
    assign o_digest_word = r_chain[r_oidx];
    assign o_word_last = (r_oidx == 3'd7);

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_digest_word))
        else $error("digest word changed under stall");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while digest is offered");
    a_round_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_LOAD |=> r_state == ST_ROUND && r_t == 6'd0)
        else $error("compression did not start at round zero");
    a_last_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_word_last && !i_stall |=> !o_valid && r_pos == 6'd0)
        else $error("no reinit after last digest word");
`endif
endmodule
